// ===== hdl/gpscal_pkg.sv =====
// ----------------------------------------------------------------------------
// gpscal_pkg
// Shared types, constants and tables for the GPS time to calendar converter.
// ----------------------------------------------------------------------------
package gpscal_pkg;

  // Widths of the input and result fields.
  localparam int unsigned WEEK_W   = 13;
  localparam int unsigned SECS_W   = 20;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned YY_W     = 7;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DOM_W    = 5;
  localparam int unsigned DOY_W    = 9;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned SEC_W    = 6;

  // Internal widths.
  localparam int unsigned DAYS_W   = 16;  // days since epoch, at most 51869
  localparam int unsigned DOW_W    = 3;
  localparam int unsigned REM_W    = 17;  // seconds within a day
  localparam int unsigned MREM_W   = 12;  // seconds within an hour
  localparam int unsigned MIDX_W   = 4;   // month index 0..11

  // Epoch and time constants.
  localparam int unsigned EPOCH_WEEK    = 782;
  localparam int unsigned EPOCH_YEAR    = 1995;
  localparam int unsigned EPOCH_YY      = EPOCH_YEAR % 100;
  localparam int unsigned EPOCH_CENT    = (EPOCH_YEAR / 100) % 4;
  localparam int unsigned SECS_PER_WEEK = 604800;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned MINS_PER_HOUR = 60;
  localparam int unsigned LAST_MONTH    = 11;
  localparam int unsigned BASE_YEAR_LEN = 365;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new input item
    logic day_split;   // split seconds of week into day and seconds of day
    logic hour_split;  // split seconds of day into hour; form days since epoch
    logic min_split;   // split seconds of hour into minute and second
    logic year_step;   // take one whole year off the day count
    logic year_fix;    // year found; set up the month search
    logic month_step;  // take one whole month off the day of month
    logic finish;      // load the result registers and strobe them
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_range;    // week and seconds are inside the supported span
    logic year_done;   // remaining days fit inside the current year
    logic month_done;  // day of month fits the current month
  } status_t;

  // Days in a month, by leap flag and month index 0..11.
  function automatic logic [DOM_W-1:0] month_len(input logic leap,
                                                 input logic [MIDX_W-1:0] mon);
    logic [DOM_W-1:0] len;
    unique case (mon)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== hdl/gps_time_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// gps_time_to_calendar_date
// Converts a GPS week number and seconds of week to a Gregorian date and time.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_gps_week, in_week_seconds and in_second_fraction and raise start.
//   The transfer is taken at a clock edge where start is high and busy is low;
//   busy then stays high until the result has been issued.
//   The result appears on the out_ ports for one cycle, marked by out_strobe,
//   and is taken at the edge that ends that cycle. The receiver cannot stall.
//   out_valid_res is low, and every other field zero, when the week precedes
//   week 782 or the seconds reach a full week.
// Sequence:
//   In range: the day, hour and minute splits run in turn, then the year
//   walk steps one year per cycle from 1995 (up to 142 whole years over the
//   full week range), then the month walk steps up through the month index
//   (0 to 11) until the day fits, and then the result is issued.
//   Out of range: the item goes from the day split straight to the result.
//   A new item can be taken in the cycle the strobe is shown.
// Reset:
//   rst_n is synchronous and active low; it returns the sequencer to idle and
//   clears the strobe. No result is pending after reset.
// ----------------------------------------------------------------------------
module gps_time_to_calendar_date (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [gpscal_pkg::WEEK_W-1:0]       in_gps_week,
  input  logic [gpscal_pkg::SECS_W-1:0]       in_week_seconds,
  input  logic [gpscal_pkg::FRAC_W-1:0]       in_second_fraction,
  output logic                                out_strobe,
  output logic                                out_valid_res,
  output logic [gpscal_pkg::YEAR_W-1:0]       out_year,
  output logic [gpscal_pkg::YY_W-1:0]         out_year_two_digit,
  output logic [gpscal_pkg::MONTH_W-1:0]      out_month,
  output logic [gpscal_pkg::DOM_W-1:0]        out_day_of_month,
  output logic [gpscal_pkg::DOY_W-1:0]        out_day_of_year,
  output logic [gpscal_pkg::HOUR_W-1:0]       out_hour,
  output logic [gpscal_pkg::MIN_W-1:0]        out_minute,
  output logic [gpscal_pkg::SEC_W-1:0]        out_second,
  output logic [gpscal_pkg::FRAC_W-1:0]       out_second_frac_out
);

  gpscal_pkg::cmd_t    cmd;
  gpscal_pkg::status_t sts;

  // Sequencer.
  gpscal_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Datapath and result registers.
  gpscal_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_gps_week         (in_gps_week),
    .in_week_seconds     (in_week_seconds),
    .in_second_fraction  (in_second_fraction),
    .out_strobe          (out_strobe),
    .out_valid_res       (out_valid_res),
    .out_year            (out_year),
    .out_year_two_digit  (out_year_two_digit),
    .out_month           (out_month),
    .out_day_of_month    (out_day_of_month),
    .out_day_of_year     (out_day_of_year),
    .out_hour            (out_hour),
    .out_minute          (out_minute),
    .out_second          (out_second),
    .out_second_frac_out (out_second_frac_out)
  );

endmodule

// ===== hdl/gpscal_ctrl.sv =====
// ----------------------------------------------------------------------------
// gpscal_ctrl
// Sequencer for the converter: splits the time of day, walks the years and
// months one per cycle, issues the result; out-of-range items skip to it.
// ----------------------------------------------------------------------------
module gpscal_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  gpscal_pkg::status_t sts,
  output gpscal_pkg::cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DAY   = 7'b0000010,
    S_HOUR  = 7'b0000100,
    S_MIN   = 7'b0001000,
    S_YEAR  = 7'b0010000,
    S_MONTH = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DAY;
        end
      end
      S_DAY: begin
        if (sts.in_range) begin
          cmd.day_split = 1'b1;
          state_nxt     = S_HOUR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_HOUR: begin
        cmd.hour_split = 1'b1;
        state_nxt      = S_MIN;
      end
      S_MIN: begin
        cmd.min_split = 1'b1;
        state_nxt     = S_YEAR;
      end
      S_YEAR: begin
        if (sts.year_done) begin
          cmd.year_fix = 1'b1;
          state_nxt    = S_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (sts.month_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // An accepted transfer always starts the day split.
  a_start_to_day: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_DAY))
    else $error("accepted item did not enter the day split");

  // The year walk stays put until the remaining days fit the year.
  a_year_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_YEAR && !sts.year_done) |=> (state_r == S_YEAR))
    else $error("year walk left before the year was found");

  // Out-of-range items skip the whole computation.
  a_range_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DAY && !sts.in_range) |=> (state_r == S_DONE))
    else $error("out-of-range item was not sent straight to the result");

endmodule

// ===== hdl/gpscal_dp.sv =====
// ----------------------------------------------------------------------------
// gpscal_dp
// Datapath of the converter: input capture, time-of-day split, year and
// month counters with leap tracking, and the result registers.
// ----------------------------------------------------------------------------
module gpscal_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gpscal_pkg::cmd_t                    cmd,
  output gpscal_pkg::status_t                 sts,
  input  logic [gpscal_pkg::WEEK_W-1:0]       in_gps_week,
  input  logic [gpscal_pkg::SECS_W-1:0]       in_week_seconds,
  input  logic [gpscal_pkg::FRAC_W-1:0]       in_second_fraction,
  output logic                                out_strobe,
  output logic                                out_valid_res,
  output logic [gpscal_pkg::YEAR_W-1:0]       out_year,
  output logic [gpscal_pkg::YY_W-1:0]         out_year_two_digit,
  output logic [gpscal_pkg::MONTH_W-1:0]      out_month,
  output logic [gpscal_pkg::DOM_W-1:0]        out_day_of_month,
  output logic [gpscal_pkg::DOY_W-1:0]        out_day_of_year,
  output logic [gpscal_pkg::HOUR_W-1:0]       out_hour,
  output logic [gpscal_pkg::MIN_W-1:0]        out_minute,
  output logic [gpscal_pkg::SEC_W-1:0]        out_second,
  output logic [gpscal_pkg::FRAC_W-1:0]       out_second_frac_out
);

  // Working registers.
  logic [gpscal_pkg::WEEK_W-1:0]  week_r;
  logic [gpscal_pkg::SECS_W-1:0]  secs_r;
  logic [gpscal_pkg::FRAC_W-1:0]  frac_r;
  logic [gpscal_pkg::REM_W-1:0]   rem_r;
  logic [gpscal_pkg::DOW_W-1:0]   dow_r;
  logic [gpscal_pkg::HOUR_W-1:0]  hr_r;
  logic [gpscal_pkg::MIN_W-1:0]   mn_r;
  logic [gpscal_pkg::SEC_W-1:0]   sc_r;
  logic [gpscal_pkg::DAYS_W-1:0]  days_r;
  logic [gpscal_pkg::YEAR_W-1:0]  year_r;
  logic [gpscal_pkg::YY_W-1:0]    yy_r;
  logic [1:0]                     cent_r;
  logic [gpscal_pkg::MIDX_W-1:0]  mon_r;
  logic [gpscal_pkg::DOY_W-1:0]   dom_r;
  logic [gpscal_pkg::DOY_W-1:0]   doy_r;

  // Result registers.
  logic                            strobe_r;
  logic                            valid_r;
  logic [gpscal_pkg::YEAR_W-1:0]   oyear_r;
  logic [gpscal_pkg::YY_W-1:0]     oyy_r;
  logic [gpscal_pkg::MONTH_W-1:0]  omon_r;
  logic [gpscal_pkg::DOM_W-1:0]    odom_r;
  logic [gpscal_pkg::DOY_W-1:0]    odoy_r;
  logic [gpscal_pkg::HOUR_W-1:0]   ohr_r;
  logic [gpscal_pkg::MIN_W-1:0]    omn_r;
  logic [gpscal_pkg::SEC_W-1:0]    osc_r;
  logic [gpscal_pkg::FRAC_W-1:0]   ofrac_r;

  // Combinational split results.
  logic [gpscal_pkg::DOW_W-1:0]   dow_nxt;
  logic [gpscal_pkg::SECS_W-1:0]  day_base;
  logic [gpscal_pkg::HOUR_W-1:0]  hr_nxt;
  logic [gpscal_pkg::REM_W-1:0]   hour_base;
  logic [gpscal_pkg::MIN_W-1:0]   mn_nxt;
  logic [gpscal_pkg::MREM_W-1:0]  min_base;
  logic [gpscal_pkg::WEEK_W-1:0]  week_off;
  logic [gpscal_pkg::DAYS_W-1:0]  days_nxt;
  logic                           leap;
  logic [gpscal_pkg::DOY_W-1:0]   year_len;
  logic [gpscal_pkg::DOM_W-1:0]   mlen;

  // Range check on the captured item.
  assign sts.in_range = (week_r >= gpscal_pkg::WEEK_W'(gpscal_pkg::EPOCH_WEEK)) &&
                        (secs_r <  gpscal_pkg::SECS_W'(gpscal_pkg::SECS_PER_WEEK));

  // Day of week: parallel compares against whole-day boundaries.
  always_comb begin
    dow_nxt  = '0;
    day_base = '0;
    for (int k = 1; k < gpscal_pkg::DAYS_PER_WEEK; k++) begin
      if (secs_r >= gpscal_pkg::SECS_W'(k * gpscal_pkg::SECS_PER_DAY)) begin
        dow_nxt  = gpscal_pkg::DOW_W'(k);
        day_base = gpscal_pkg::SECS_W'(k * gpscal_pkg::SECS_PER_DAY);
      end
    end
  end

  // Hour of day: parallel compares against hour boundaries.
  always_comb begin
    hr_nxt    = '0;
    hour_base = '0;
    for (int k = 1; k < gpscal_pkg::HOURS_PER_DAY; k++) begin
      if (rem_r >= gpscal_pkg::REM_W'(k * gpscal_pkg::SECS_PER_HOUR)) begin
        hr_nxt    = gpscal_pkg::HOUR_W'(k);
        hour_base = gpscal_pkg::REM_W'(k * gpscal_pkg::SECS_PER_HOUR);
      end
    end
  end

  // Minute of hour: parallel compares against minute boundaries.
  always_comb begin
    mn_nxt   = '0;
    min_base = '0;
    for (int k = 1; k < gpscal_pkg::MINS_PER_HOUR; k++) begin
      if (rem_r[gpscal_pkg::MREM_W-1:0] >=
          gpscal_pkg::MREM_W'(k * gpscal_pkg::SECS_PER_MIN)) begin
        mn_nxt   = gpscal_pkg::MIN_W'(k);
        min_base = gpscal_pkg::MREM_W'(k * gpscal_pkg::SECS_PER_MIN);
      end
    end
  end

  // Days since epoch: weeks times seven, as eight minus one, plus the day.
  assign week_off = week_r - gpscal_pkg::WEEK_W'(gpscal_pkg::EPOCH_WEEK);
  assign days_nxt = ({week_off, 3'b000} - gpscal_pkg::DAYS_W'(week_off)) +
                    gpscal_pkg::DAYS_W'(dow_r);

  // Gregorian leap rule from the year counters: divisible by four, and
  // either not a century or a century divisible by four hundred.
  assign leap     = (year_r[1:0] == 2'b00) && ((yy_r != '0) || (cent_r == 2'b00));
  assign year_len = gpscal_pkg::DOY_W'(gpscal_pkg::BASE_YEAR_LEN) +
                    gpscal_pkg::DOY_W'(leap);
  assign mlen     = gpscal_pkg::month_len(leap, mon_r);

  assign sts.year_done  = (days_r < gpscal_pkg::DAYS_W'(year_len));
  assign sts.month_done = (mon_r == gpscal_pkg::MIDX_W'(gpscal_pkg::LAST_MONTH)) ||
                          (dom_r <= gpscal_pkg::DOY_W'(mlen));

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      week_r <= in_gps_week;
      secs_r <= in_week_seconds;
      frac_r <= in_second_fraction;
      year_r <= gpscal_pkg::YEAR_W'(gpscal_pkg::EPOCH_YEAR);
      yy_r   <= gpscal_pkg::YY_W'(gpscal_pkg::EPOCH_YY);
      cent_r <= 2'(gpscal_pkg::EPOCH_CENT);
    end
    if (cmd.day_split) begin
      dow_r <= dow_nxt;
      rem_r <= gpscal_pkg::REM_W'(secs_r - day_base);
    end
    if (cmd.hour_split) begin
      hr_r   <= hr_nxt;
      rem_r  <= rem_r - hour_base;
      days_r <= days_nxt;
    end
    if (cmd.min_split) begin
      mn_r <= mn_nxt;
      sc_r <= gpscal_pkg::SEC_W'(rem_r[gpscal_pkg::MREM_W-1:0] - min_base);
    end
    // One year per cycle; the two-digit year and century wrap together.
    if (cmd.year_step) begin
      days_r <= days_r - gpscal_pkg::DAYS_W'(year_len);
      year_r <= year_r + 1'b1;
      if (yy_r == gpscal_pkg::YY_W'(99)) begin
        yy_r   <= '0;
        cent_r <= cent_r + 1'b1;
      end else begin
        yy_r <= yy_r + 1'b1;
      end
    end
    if (cmd.year_fix) begin
      doy_r <= gpscal_pkg::DOY_W'(days_r) + 1'b1;
      dom_r <= gpscal_pkg::DOY_W'(days_r) + 1'b1;
      mon_r <= '0;
    end
    if (cmd.month_step) begin
      dom_r <= dom_r - gpscal_pkg::DOY_W'(mlen);
      mon_r <= mon_r + 1'b1;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.finish;
    end
  end

  // Result payload; an out-of-range item gives all zeros.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (sts.in_range) begin
        valid_r <= 1'b1;
        oyear_r <= year_r;
        oyy_r   <= yy_r;
        omon_r  <= mon_r + 1'b1;
        odom_r  <= dom_r[gpscal_pkg::DOM_W-1:0];
        odoy_r  <= doy_r;
        ohr_r   <= hr_r;
        omn_r   <= mn_r;
        osc_r   <= sc_r;
        ofrac_r <= frac_r;
      end else begin
        valid_r <= 1'b0;
        oyear_r <= '0;
        oyy_r   <= '0;
        omon_r  <= '0;
        odom_r  <= '0;
        odoy_r  <= '0;
        ohr_r   <= '0;
        omn_r   <= '0;
        osc_r   <= '0;
        ofrac_r <= '0;
      end
    end
  end

  assign out_strobe          = strobe_r;
  assign out_valid_res       = valid_r;
  assign out_year            = oyear_r;
  assign out_year_two_digit  = oyy_r;
  assign out_month           = omon_r;
  assign out_day_of_month    = odom_r;
  assign out_day_of_year     = odoy_r;
  assign out_hour            = ohr_r;
  assign out_minute          = omn_r;
  assign out_second          = osc_r;
  assign out_second_frac_out = ofrac_r;

  // A finish command always produces a strobed result in the next cycle.
  a_finish_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> strobe_r)
    else $error("finish did not strobe a result");

  // A valid result carries a month in calendar range.
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && valid_r) |-> (omon_r >= 4'd1 && omon_r <= 4'd12))
    else $error("valid result with a month out of range");

  // Each year step advances the year by exactly one.
  a_year_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.year_step |=> (year_r == $past(year_r) + 1'b1))
    else $error("year counter did not advance by one");

endmodule
